FILE: design/csc_pkg.sv
// Shared types, reset values and scan tables for the charlieplex sequence controller.
package csc_pkg;

    // Widths of the configuration registers and payload fields
    localparam int unsigned TickW   = 16;
    localparam int unsigned PeriodW = 10;
    localparam int unsigned DebW    = 8;
    localparam int unsigned PinW    = 4;
    localparam int unsigned LightW  = 8;
    localparam int unsigned ScanW   = 4;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = TickW;

    // Register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_PERIOD   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_PERIODS_BEFORE_OFF = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_DIVIDER   = 2'd2;

    // Register reset values
    localparam logic [TickW-1:0]   TicksPerPeriodRst   = 16'd46875;
    localparam logic [PeriodW-1:0] PeriodsBeforeOffRst = 10'd360;
    localparam logic [DebW-1:0]    DebounceDividerRst  = 8'd46;

    // Light mask codes
    localparam logic [LightW-1:0] FirstLight = 8'h80;
    localparam logic [LightW-1:0] AllLights  = 8'hFF;

    // Last scan position; it is always lit
    localparam logic [ScanW-1:0] ScanLast = 4'd8;

    typedef struct packed {
        logic [TickW-1:0]   ticks_per_period;
        logic [PeriodW-1:0] periods_before_off;
        logic [DebW-1:0]    debounce_divider;
    } t_cfg;

    typedef struct packed {
        logic [PinW-1:0]   led_drive;
        logic [PinW-1:0]   led_high;
        logic [LightW-1:0] lit_mask;
        logic              asleep;
    } t_result;

    // Pin direction pattern for each scan position
    function automatic logic [PinW-1:0] drive_pattern(input logic [ScanW-1:0] pos);
        logic [PinW-1:0] d;
        begin
            case (pos)
                4'd0, 4'd1: d = 4'hC;
                4'd2, 4'd3: d = 4'h5;
                4'd4, 4'd5: d = 4'h3;
                4'd6, 4'd7: d = 4'h9;
                4'd8:       d = 4'hA;
                default:    d = 4'h0;
            endcase
            return d;
        end
    endfunction

    // Pin level pattern for each scan position
    function automatic logic [PinW-1:0] high_pattern(input logic [ScanW-1:0] pos);
        logic [PinW-1:0] h;
        begin
            case (pos)
                4'd0:       h = 4'h4;
                4'd1:       h = 4'h8;
                4'd2:       h = 4'h1;
                4'd3:       h = 4'h4;
                4'd4:       h = 4'h2;
                4'd5, 4'd6: h = 4'h1;
                4'd7:       h = 4'h8;
                4'd8:       h = 4'h2;
                default:    h = 4'h0;
            endcase
            return h;
        end
    endfunction

endpackage

FILE: design/csc_cfg_regs.sv
// Configuration registers of the charlieplex sequence controller.
module csc_cfg_regs
    import csc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    // Decode the index and load the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_period   <= TicksPerPeriodRst;
            r_cfg.periods_before_off <= PeriodsBeforeOffRst;
            r_cfg.debounce_divider   <= DebounceDividerRst;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TICKS_PER_PERIOD:
                    r_cfg.ticks_per_period <= i_cfg_data;
                CFG_PERIODS_BEFORE_OFF:
                    r_cfg.periods_before_off <= i_cfg_data[PeriodW-1:0];
                CFG_DEBOUNCE_DIVIDER:
                    r_cfg.debounce_divider <= i_cfg_data[DebW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/csc_core.sv
// Timers, key debounce, light sequencing and scan state; computes one result per tick.
module csc_core
    import csc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_tick,
    input  logic    i_key_pin,
    output t_result o_result
);

    logic [TickW-1:0]   r_tick_count,  n_tick_count;
    logic [PeriodW-1:0] r_period_count, n_period_count;
    logic [DebW-1:0]    r_deb_count,   n_deb_count;
    logic               r_vert_low,    n_vert_low;
    logic               r_vert_high,   n_vert_high;
    logic               r_deb_key,     n_deb_key;
    logic               r_press,       n_press;
    logic [LightW-1:0]  r_light_mask,  n_light_mask;
    logic [ScanW-1:0]   r_scan_pos,    n_scan_pos;
    logic               r_sleeping,    n_sleeping;

    logic auto_off;
    logic sample;
    logic chg;
    logic chg_done;
    logic lit;

    always_comb begin
        n_tick_count   = r_tick_count;
        n_period_count = r_period_count;
        n_deb_count    = r_deb_count;
        n_vert_low     = r_vert_low;
        n_vert_high    = r_vert_high;
        n_deb_key      = r_deb_key;
        n_press        = r_press;
        n_light_mask   = r_light_mask;
        n_scan_pos     = r_scan_pos;
        n_sleeping     = r_sleeping;
        auto_off       = 1'b0;
        sample         = 1'b0;
        chg            = 1'b0;
        chg_done       = 1'b0;
        lit            = 1'b0;
        o_result       = '0;

        if (r_sleeping) begin
            // Hold everything; a pressed pin wakes the block
            if (!i_key_pin) begin
                n_sleeping = 1'b0;
            end
            o_result.asleep = 1'b1;
        end else begin
            // Advance the auto-off tick and period counters
            if (r_tick_count >= i_cfg.ticks_per_period) begin
                n_tick_count = '0;
                if (r_period_count >= i_cfg.periods_before_off) begin
                    n_period_count = '0;
                    auto_off       = 1'b1;
                end else begin
                    n_period_count = r_period_count + 1'b1;
                end
            end else begin
                n_tick_count = r_tick_count + 1'b1;
            end

            // Advance the debounce divider; sample the key when it wraps
            if (r_deb_count >= i_cfg.debounce_divider) begin
                n_deb_count = '0;
                sample      = 1'b1;
            end else begin
                n_deb_count = r_deb_count + 1'b1;
            end

            // Two-bit vertical counter: the key state flips after four equal samples
            if (sample) begin
                chg         = r_deb_key ^ ~i_key_pin;
                n_vert_low  = ~(r_vert_low & chg);
                n_vert_high = n_vert_low ^ (r_vert_high & chg);
                chg_done    = chg & n_vert_low & n_vert_high;
                n_deb_key   = r_deb_key ^ chg_done;
                n_press     = r_press | (n_deb_key & chg_done);
            end

            // Auto-off wins over a pending press, which then stays pending
            if (auto_off) begin
                n_light_mask = '0;
                n_sleeping   = 1'b1;
            end else if (n_press) begin
                n_press = 1'b0;
                if (r_light_mask == '0) begin
                    n_light_mask = FirstLight;
                end else if (r_light_mask == AllLights) begin
                    n_light_mask = '0;
                    n_sleeping   = 1'b1;
                end else begin
                    n_light_mask = {1'b1, r_light_mask[LightW-1:1]};
                end
            end

            // Step the scan and drive the light under it if lit
            if (n_sleeping) begin
                o_result.asleep = 1'b1;
            end else begin
                n_scan_pos = (r_scan_pos >= ScanLast) ? '0 : r_scan_pos + 1'b1;
                lit = (n_scan_pos == ScanLast) || n_light_mask[n_scan_pos[2:0]];
                if (lit) begin
                    o_result.led_drive = drive_pattern(n_scan_pos);
                    o_result.led_high  = high_pattern(n_scan_pos);
                end
                o_result.lit_mask = n_light_mask;
            end
        end
    end

    // Commit the state on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count   <= '0;
            r_period_count <= '0;
            r_deb_count    <= '0;
            r_vert_low     <= 1'b0;
            r_vert_high    <= 1'b0;
            r_deb_key      <= 1'b0;
            r_press        <= 1'b0;
            r_light_mask   <= '0;
            r_scan_pos     <= '0;
            r_sleeping     <= 1'b0;
        end else if (i_tick) begin
            r_tick_count   <= n_tick_count;
            r_period_count <= n_period_count;
            r_deb_count    <= n_deb_count;
            r_vert_low     <= n_vert_low;
            r_vert_high    <= n_vert_high;
            r_deb_key      <= n_deb_key;
            r_press        <= n_press;
            r_light_mask   <= n_light_mask;
            r_scan_pos     <= n_scan_pos;
            r_sleeping     <= n_sleeping;
        end
    end

`ifndef SYNTH
    a_sleep_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sleeping |-> (r_light_mask == '0))
        else $error("light mask not cleared while asleep");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_pos <= ScanLast)
        else $error("scan position out of range");

    a_sleep_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sleeping |=> ($stable(r_tick_count) && $stable(r_deb_count)
                        && $stable(r_scan_pos)))
        else $error("counters moved while asleep");
`endif

endmodule

FILE: design/charlieplex_sequence_controller_unit.sv
// Top level of the charlieplex sequence controller: handshake, result register, configuration.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+------------------------------------------------
//  tick in | i_valid | o_stall | i_key_pin
//  result  | o_valid | i_stall | o_led_drive, o_led_high, o_lit_mask, o_asleep
//  config  | i_cfg_wr_en (no stall) | i_cfg_index, i_cfg_data
//
// One request is taken every cycle unless stalled; the result register captures its result.
// The single result register holds that result; the core state updates on the accept edge.
// A request is taken while a result waits, provided the result leaves in the same cycle.
// Synchronous active-low reset loads the register defaults and clears all state but r_result.
// o_stall rises only while a result is held and the result side stalls.
module charlieplex_sequence_controller_unit
    import csc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_key_pin,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [PinW-1:0]     o_led_drive,
    output logic [PinW-1:0]     o_led_high,
    output logic [LightW-1:0]   o_lit_mask,
    output logic                o_asleep,
    input  logic                i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_result result;
    t_result r_result;
    logic    r_valid;
    logic    accept;

    csc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    csc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_tick    (accept),
        .i_key_pin (i_key_pin),
        .o_result  (result)
    );

    // Stall the request side only while a held result cannot leave
    assign o_stall = r_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    // Track result register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Load the result payload on each accepted request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_valid     = r_valid;
    assign o_led_drive = r_result.led_drive;
    assign o_led_high  = r_result.led_high;
    assign o_lit_mask  = r_result.lit_mask;
    assign o_asleep    = r_result.asleep;

endmodule

FILE: sim/csc_frame_checker.sv
// Scoreboard for the charlieplex sequence controller: predicts each pin frame and compares it.
`timescale 1ns / 1ps
module csc_frame_checker
    import csc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick_valid,
    input  logic                i_tick_stall,
    input  logic                i_key_pin,
    input  logic                i_res_valid,
    input  logic                i_res_stall,
    input  logic [PinW-1:0]     i_led_drive,
    input  logic [PinW-1:0]     i_led_high,
    input  logic [LightW-1:0]   i_lit_mask,
    input  logic                i_asleep,
    input  logic                i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output int                  o_errors,
    output int                  o_frames_due
);

    // Pin patterns per scan position, position 0 in the low nibble
    localparam logic [9*PinW-1:0] ScanDrive = {4'hA, 4'h9, 4'h9, 4'h3, 4'h3,
                                               4'h5, 4'h5, 4'hC, 4'hC};
    localparam logic [9*PinW-1:0] ScanHigh  = {4'h2, 4'h8, 4'h1, 4'h1, 4'h2,
                                               4'h4, 4'h1, 4'h8, 4'h4};

    // Shadow copy of the registers
    logic [TickW-1:0]   cfg_ticks;
    logic [PeriodW-1:0] cfg_periods;
    logic [DebW-1:0]    cfg_debounce;

    // Shadow copy of the controller state
    logic [TickW-1:0]   tick_cnt;
    logic [PeriodW-1:0] period_cnt;
    logic [DebW-1:0]    sample_cnt;
    logic               vc_low;
    logic               vc_high;
    logic               deb_level;
    logic               press_latched;
    logic [LightW-1:0]  lights;
    logic [ScanW-1:0]   scan_pos;
    logic               dozing;

    t_result pin_frames_due[$];
    int      mismatches = 0;
    int      frame_no = 0;

    // Advance the shadow state by one tick and return the frame it drives
    function automatic t_result next_pin_frame(input logic key);
        t_result          f;
        logic [TickW:0]   t;
        logic [PeriodW:0] p;
        logic [DebW:0]    d;
        logic             chg;
        logic             off_now;
        f = '0;
        off_now = 1'b0;
        if (dozing) begin
            // any pressed level wakes; this tick still reports sleep
            if (!key) dozing = 1'b0;
            f.asleep = 1'b1;
            return f;
        end
        // auto-off timer
        t = tick_cnt + 1'b1;
        if (t > cfg_ticks) begin
            tick_cnt = '0;
            p = period_cnt + 1'b1;
            if (p > cfg_periods) begin
                period_cnt = '0;
                off_now = 1'b1;
            end else begin
                period_cnt = p[PeriodW-1:0];
            end
        end else begin
            tick_cnt = t[TickW-1:0];
        end
        // two-bit vertical counter debounce, latch a new press
        d = sample_cnt + 1'b1;
        if (d > cfg_debounce) begin
            sample_cnt = '0;
            chg = deb_level ^ ~key;
            vc_low = ~(vc_low & chg);
            vc_high = vc_low ^ (vc_high & chg);
            chg = chg & vc_low & vc_high;
            deb_level = deb_level ^ chg;
            press_latched = press_latched | (deb_level & chg);
        end else begin
            sample_cnt = d[DebW-1:0];
        end
        // auto-off wins over a pending press, which then stays latched
        if (off_now) begin
            lights = '0;
            dozing = 1'b1;
        end else if (press_latched) begin
            press_latched = 1'b0;
            if (lights == '0) begin
                lights = FirstLight;
            end else if (lights == AllLights) begin
                lights = '0;
                dozing = 1'b1;
            end else begin
                lights = (lights >> 1) | FirstLight;
            end
        end
        // advance the scan and drive the light at the new position
        if (!dozing) begin
            scan_pos = (scan_pos >= ScanLast) ? '0 : scan_pos + 1'b1;
            if (scan_pos == ScanLast || lights[scan_pos[2:0]]) begin
                f.led_drive = ScanDrive[scan_pos*PinW +: PinW];
                f.led_high  = ScanHigh[scan_pos*PinW +: PinW];
            end
        end
        f.lit_mask = lights;
        f.asleep = dozing;
        return f;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        if (mismatches < 10) begin
            $display("frame %0d: %s expected 0x%0h got 0x%0h", frame_no, what, want, got);
        end
        mismatches++;
    endtask

    // Track registers, predict on each accepted request, compare each accepted frame
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg_ticks     = TicksPerPeriodRst;
            cfg_periods   = PeriodsBeforeOffRst;
            cfg_debounce  = DebounceDividerRst;
            tick_cnt      = '0;
            period_cnt    = '0;
            sample_cnt    = '0;
            vc_low        = 1'b0;
            vc_high       = 1'b0;
            deb_level     = 1'b0;
            press_latched = 1'b0;
            lights        = '0;
            scan_pos      = '0;
            dozing        = 1'b0;
            pin_frames_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_TICKS_PER_PERIOD:   cfg_ticks = i_cfg_data[TickW-1:0];
                    CFG_PERIODS_BEFORE_OFF: cfg_periods = i_cfg_data[PeriodW-1:0];
                    CFG_DEBOUNCE_DIVIDER:   cfg_debounce = i_cfg_data[DebW-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (pin_frames_due.size() == 0) begin
                    note_mismatch("frame with no request pending, lit_mask", 0, i_lit_mask);
                end else begin
                    want = pin_frames_due.pop_front();
                    if (i_led_drive !== want.led_drive)
                        note_mismatch("led_drive", want.led_drive, i_led_drive);
                    if (i_led_high !== want.led_high)
                        note_mismatch("led_high", want.led_high, i_led_high);
                    if (i_lit_mask !== want.lit_mask)
                        note_mismatch("lit_mask", want.lit_mask, i_lit_mask);
                    if (i_asleep !== want.asleep)
                        note_mismatch("asleep", want.asleep, i_asleep);
                end
                frame_no++;
            end
            if (i_tick_valid && !i_tick_stall) begin
                pin_frames_due.push_back(next_pin_frame(i_key_pin));
            end
        end
        o_errors <= mismatches;
        o_frames_due <= pin_frames_due.size();
    end

endmodule

FILE: sim/charlieplex_sequence_controller_unit_tb.sv
// Testbench top for the charlieplex sequence controller: stimulus, idling and verdict.
`timescale 1ns / 1ps
module charlieplex_sequence_controller_unit_tb;
    import csc_pkg::*;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    typedef struct packed {
        logic [TickW-1:0]   ticks;
        logic [PeriodW-1:0] periods;
        logic [DebW-1:0]    debounce;
        t_idle              idle;
        logic [15:0]        requests;
        logic               hold;
    } t_phase;

    localparam int NumPhases = 6;
    localparam int CycleLimit = 400000;
    localparam int HoldCycles = 60;
    localparam int MaxGap = 40;
    localparam int MaxRun = 300;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                tick_valid = 1'b0;
    logic                tick_stall;
    logic                key_pin = 1'b1;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [PinW-1:0]     led_drive;
    logic [PinW-1:0]     led_high;
    logic [LightW-1:0]   lit_mask;
    logic                asleep;
    logic                cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    int                  errors;
    int                  frames_due;

    int     stall_pct = 0;
    int     send_idle_pct = 0;
    int     hold_req = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     cycles = 0;
    logic   key_level = 1'b1;
    int     run_left = 0;
    int     noise_left = 0;
    t_phase plan [NumPhases];

    charlieplex_sequence_controller_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (tick_valid),
        .o_stall     (tick_stall),
        .i_key_pin   (key_pin),
        .o_valid     (res_valid),
        .i_stall     (res_stall),
        .o_led_drive (led_drive),
        .o_led_high  (led_high),
        .o_lit_mask  (lit_mask),
        .o_asleep    (asleep),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    csc_frame_checker frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_tick_valid (tick_valid),
        .i_tick_stall (tick_stall),
        .i_key_pin    (key_pin),
        .i_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .i_led_drive  (led_drive),
        .i_led_high   (led_high),
        .i_lit_mask   (lit_mask),
        .i_asleep     (asleep),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_errors     (errors),
        .o_frames_due (frames_due)
    );

    always #5 clk = ~clk;

    // Stop a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("charlieplex_sequence_controller_unit test failed");
            $finish;
        end
    end

    // Result side: long hold-off on demand, otherwise random stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else if (hold_left != 0) begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HoldCycles;
            res_stall <= 1'b1;
        end else begin
            res_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Button level: mostly held presses and releases, some bounce noise
    function automatic logic pick_key(input logic [DebW-1:0] debounce);
        int unsigned span;
        span = (int'(debounce) + 1) * $urandom_range(4, 7);
        if (noise_left == 0 && run_left == 0) begin
            if ($urandom_range(0, 99) < 20) begin
                noise_left = $urandom_range(1, 12);
            end else begin
                key_level = ~key_level;
                run_left = (span > MaxRun) ? MaxRun : span;
            end
        end
        if (noise_left > 0) begin
            noise_left--;
            return 1'($urandom_range(0, 1));
        end
        run_left--;
        return key_level;
    endfunction

    // Offer one tick request and hold it until taken
    task automatic send_tick(input logic key);
        int gap;
        gap = 0;
        while (gap < MaxGap && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        key_pin <= key;
        do @(posedge clk); while (tick_stall);
    endtask

    // Drop valid and wait until every frame has come back
    task automatic drain();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (frames_due != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Load all registers; junk in the unused upper bits and an unmapped index
    task automatic program_config(input logic [TickW-1:0] ticks,
                                  input logic [PeriodW-1:0] periods,
                                  input logic [DebW-1:0] debounce);
        write_reg(CFG_TICKS_PER_PERIOD, ticks);
        write_reg(CFG_PERIODS_BEFORE_OFF, {6'($urandom), periods});
        write_reg(CFG_DEBOUNCE_DIVIDER, {8'($urandom), debounce});
        write_reg(CFG_UNUSED, 16'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        t_phase ph;
        logic [19:0] wake_seq;
        plan[0] = '{16'd0, 10'd1, 8'd0, IDLE_NONE, 16'd60, 1'b0};
        plan[1] = '{16'd3, 10'd60, 8'd1, IDLE_SENDER, 16'd200, 1'b0};
        plan[2] = '{16'd65535, 10'd1023, 8'd1, IDLE_RECEIVER, 16'd230, 1'b0};
        plan[3] = '{16'd1, 10'd1, 8'd2, IDLE_BOTH, 16'd200, 1'b0};
        plan[4] = '{16'($urandom_range(4, 20)), 10'($urandom_range(20, 60)), 8'd255,
                    IDLE_BOTH, 16'd160, 1'b0};
        plan[5] = '{16'($urandom_range(0, 15)), 10'($urandom_range(5, 40)),
                    8'($urandom_range(0, 3)), IDLE_NONE, 16'd100, 1'b1};
        // press, bounce, release, press across auto-off and wake
        wake_seq = 20'b0101_1000_0011_1100_0001;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // a few ticks with the register defaults
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // sample every tick, auto-off every fourth tick
        drain();
        program_config(16'd0, 10'd3, 8'd0);
        for (int i = 0; i < 20; i++) send_tick(wake_seq[i]);

        for (int n = 0; n < NumPhases; n++) begin
            ph = plan[n];
            drain();
            program_config(ph.ticks, ph.periods, ph.debounce);
            case (ph.idle)
                IDLE_NONE: begin
                    stall_pct <= 0;
                    send_idle_pct = 0;
                end
                IDLE_SENDER: begin
                    stall_pct <= 0;
                    send_idle_pct = 73;
                end
                IDLE_RECEIVER: begin
                    stall_pct <= 73;
                    send_idle_pct = 0;
                end
                default: begin
                    stall_pct <= 33;
                    send_idle_pct = 33;
                end
            endcase
            // hold off the result side while requests keep coming
            if (ph.hold) hold_req <= hold_req + 1;
            for (int i = 0; i < ph.requests; i++) send_tick(pick_key(ph.debounce));
        end

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0 && frames_due == 0) begin
            $display("charlieplex_sequence_controller_unit test passed");
        end else begin
            $display("charlieplex_sequence_controller_unit test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
design/csc_pkg.sv
design/csc_cfg_regs.sv
design/csc_core.sv
design/charlieplex_sequence_controller_unit.sv
sim/csc_frame_checker.sv
sim/charlieplex_sequence_controller_unit_tb.sv
